### rtl/core/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, constants and hash helpers of the count-min sketch flow
// counter.
// ----------------------------------------------------------------------------
package cms_pkg;

   localparam int unsigned CMS_ROWS_DEFAULT    = 4;
   localparam int unsigned CMS_COLUMNS_DEFAULT = 1024;

   localparam int unsigned COUNT_WIDTH = 64;
   localparam int unsigned HASH_WIDTH  = 32;
   localparam int unsigned SEED_COUNT  = 4;

   typedef logic [HASH_WIDTH-1:0]  hash_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam hash_type MIX_MULT = 32'h5bd1e995;
   localparam hash_type FIN_MULT = 32'h85ebca6b;

   localparam hash_type SEED_ROW0_RESET = 32'hdeadbeef;
   localparam hash_type SEED_ROW1_RESET = 32'hcafebabe;
   localparam hash_type SEED_ROW2_RESET = 32'h12345678;
   localparam hash_type SEED_ROW3_RESET = 32'habcdef01;

   localparam logic [1:0] CSR_SEED_ROW0 = 2'd0;
   localparam logic [1:0] CSR_SEED_ROW1 = 2'd1;
   localparam logic [1:0] CSR_SEED_ROW2 = 2'd2;
   localparam logic [1:0] CSR_SEED_ROW3 = 2'd3;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   function automatic hash_type rotl13(input hash_type v);
      return {v[18:0], v[31:19]};
   endfunction

endpackage

### rtl/core/count_min_sketch_flow_counter.sv
// ----------------------------------------------------------------------------
// count_min_sketch_flow_counter
// Count-min sketch over flow five-tuples: one hashed 64-bit counter per row
// is incremented per count word, the minimum of the new counts is returned;
// a read word returns one counter cell, or zero when the cell is out of range.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake            Payload
//   req_*        in         req_valid/req_stall  opcode, five-tuple, read cell
//   rsp_*        out        rsp_valid/rsp_stall  count_value
//   csr_*        in         csr_write_enable     csr_index, csr_write_data
//
// A count word runs, for each row, four steps of the shared hash multiplier,
// a RAM read, the increment and the write back, then posts the result. A read
// word reads one cell and posts it; an out-of-range read posts zero without a
// RAM read. The counter RAM has one read and one write port. After reset a
// clearing pass writes zero to all ROWS*COLUMNS cells, one per cycle, while
// req_stall stays high. The result register frees the input side; a stalled
// result only holds the block when the next result is ready.
// ----------------------------------------------------------------------------
module count_min_sketch_flow_counter
   import cms_pkg::*;
#(
   parameter int unsigned ROWS    = CMS_ROWS_DEFAULT,
   parameter int unsigned COLUMNS = CMS_COLUMNS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_destination_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_destination_port,
   input  logic [7:0]  req_protocol_number,
   input  logic [1:0]  req_read_row,
   input  logic [9:0]  req_read_column,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_count_value,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned DEPTH = ROWS * COLUMNS;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(COLUMNS);
   localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_ADDR  = 4'd3;
   localparam logic [3:0] S_DATA  = 4'd4;
   localparam logic [3:0] S_WRITE = 4'd5;
   localparam logic [3:0] S_RREAD = 4'd6;
   localparam logic [3:0] S_RDATA = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]      state_ff, state_in;
   logic [AW-1:0]   clear_addr_ff, clear_addr_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [1:0]      step_ff, step_in;
   hash_type        seed_ff [SEED_COUNT];
   hash_type        seed_in [SEED_COUNT];
   hash_type        sa_ff, sa_in;
   hash_type        da_ff, da_in;
   hash_type        ports_ff, ports_in;
   logic [7:0]      proto_ff, proto_in;
   logic [1:0]      rd_row_ff, rd_row_in;
   logic [9:0]      rd_col_ff, rd_col_in;
   hash_type        h_ff, h_in;
   logic [AW-1:0]   addr_ff, addr_in;
   count_type       nv_ff, nv_in;
   count_type       min_ff, min_in;
   count_type       result_ff, result_in;
   logic            rsp_valid_ff, rsp_valid_in;
   count_type       rsp_value_ff, rsp_value_in;

   hash_type        hash_x;
   hash_type        hash_y;
   hash_type        mul_a;
   hash_type        mul_b;
   hash_type        mul_p;
   hash_type        h_final;
   logic [CW-1:0]   hash_col;
   logic [AW-1:0]   hash_addr;
   logic [AW-1:0]   cell_addr;
   logic            read_in_range;
   count_type       nv_min;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   count_type       ram_wdata;
   logic [AW-1:0]   ram_raddr;
   count_type       ram_rdata;

   cms_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_counter_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   always_comb begin
      case (step_ff)
         2'd0:    hash_x = seed_ff[2'(row_ff)] ^ sa_ff;
         2'd1:    hash_x = h_ff ^ da_ff;
         2'd2:    hash_x = h_ff ^ ports_ff;
         default: hash_x = h_ff ^ {24'd0, proto_ff};
      endcase
      hash_y = hash_x ^ (hash_x >> 15);
      if (step_ff == 2'd3) begin
         mul_a = hash_y;
         mul_b = FIN_MULT;
      end else begin
         mul_a = rotl13(hash_x);
         mul_b = MIX_MULT;
      end
   end

   assign mul_p     = mul_a * mul_b;
   assign h_final   = h_ff ^ (h_ff >> 13);
   assign hash_col  = h_final[CW-1:0] & CW'(COLUMNS - 1);
   assign hash_addr = AW'(row_ff) * AW'(COLUMNS) + AW'(hash_col);
   assign cell_addr = AW'(rd_row_ff) * AW'(COLUMNS) + AW'(rd_col_ff);
   assign read_in_range = (3'(req_read_row) < 3'(ROWS))
                       && (17'(req_read_column) < 17'(COLUMNS));
   assign nv_min    = (nv_ff < min_ff) ? nv_ff : min_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = nv_ff;
      ram_raddr = (state_ff == S_RREAD) ? cell_addr : hash_addr;
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clear_addr_ff;
         ram_wdata = '0;
      end else if (state_ff == S_WRITE) begin
         ram_we = 1'b1;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      row_in        = row_ff;
      step_in       = step_ff;
      seed_in       = seed_ff;
      sa_in         = sa_ff;
      da_in         = da_ff;
      ports_in      = ports_ff;
      proto_in      = proto_ff;
      rd_row_in     = rd_row_ff;
      rd_col_in     = rd_col_ff;
      h_in          = h_ff;
      addr_in       = addr_ff;
      nv_in         = nv_ff;
      min_in        = min_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_SEED_ROW0: seed_in[0] = csr_write_data;
            CSR_SEED_ROW1: seed_in[1] = csr_write_data;
            CSR_SEED_ROW2: seed_in[2] = csr_write_data;
            CSR_SEED_ROW3: seed_in[3] = csr_write_data;
            default:       seed_in[0] = seed_ff[0];
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clear_addr_in = clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               sa_in     = req_source_address;
               da_in     = req_destination_address;
               ports_in  = {req_destination_port, req_source_port};
               proto_in  = req_protocol_number;
               rd_row_in = req_read_row;
               rd_col_in = req_read_column;
               row_in    = '0;
               step_in   = 2'd0;
               min_in    = '1;
               if (req_opcode == OP_COUNT) begin
                  state_in = S_HASH;
               end else if (read_in_range) begin
                  state_in = S_RREAD;
               end else begin
                  result_in = '0;
                  state_in  = S_DONE;
               end
            end
         end
         S_HASH: begin
            h_in    = mul_p;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in  = hash_addr;
            state_in = S_DATA;
         end
         S_DATA: begin
            nv_in    = ram_rdata + 64'd1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            min_in = nv_min;
            if (row_ff == RW'(ROWS - 1)) begin
               result_in = nv_min;
               state_in  = S_DONE;
            end else begin
               row_in   = row_ff + RW'(1);
               step_in  = 2'd0;
               state_in = S_HASH;
            end
         end
         S_RREAD: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            result_in = ram_rdata;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         row_ff        <= '0;
         step_ff       <= 2'd0;
         rsp_valid_ff  <= 1'b0;
         seed_ff[0]    <= SEED_ROW0_RESET;
         seed_ff[1]    <= SEED_ROW1_RESET;
         seed_ff[2]    <= SEED_ROW2_RESET;
         seed_ff[3]    <= SEED_ROW3_RESET;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         row_ff        <= row_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         seed_ff       <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff        <= sa_in;
      da_ff        <= da_in;
      ports_ff     <= ports_in;
      proto_ff     <= proto_in;
      rd_row_ff    <= rd_row_in;
      rd_col_ff    <= rd_col_in;
      h_ff         <= h_in;
      addr_ff      <= addr_in;
      nv_ff        <= nv_in;
      min_ff       <= min_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_value_ff;

endmodule

### rtl/core/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cms_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_address,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_address,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

### tb/tb_count_min_sketch_flow_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_count_min_sketch_flow_counter
// Drives flow count and cell read words into the sketch. Both sides idle and
// stall at random. A local model of the hash rows and counters predicts each
// count_value that a directed word does not fix. Several seed settings are run,
// the extremes among them, and the seeds change only while the block is drained.
// ----------------------------------------------------------------------------
module tb_count_min_sketch_flow_counter;
   import cms_pkg::*;

   localparam int unsigned SKETCH_ROWS   = CMS_ROWS_DEFAULT;
   localparam int unsigned SKETCH_COLS   = CMS_COLUMNS_DEFAULT;
   localparam int unsigned COL_BITS      = $clog2(SKETCH_COLS);
   localparam int unsigned SETTLE_CYCLES = 7 * SKETCH_ROWS + 12;
   localparam int unsigned STALL_LIMIT   = 20000;
   localparam int unsigned POOL_SIZE     = 16;
   localparam int unsigned PHASE_WORDS   = 216;

   typedef struct packed {
      logic        opcode;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [7:0]  protocol_number;
      logic [1:0]  read_row;
      logic [9:0]  read_column;
   } flow_word_type;

   typedef struct packed {
      flow_word_type word;
      bit            aim;
      bit            typed;
      count_type     value;
   } directed_row_type;

   logic        clock                   = 1'b0;
   logic        reset                   = 1'b1;
   logic        req_valid               = 1'b0;
   logic        req_opcode              = OP_COUNT;
   logic [31:0] req_source_address      = '0;
   logic [31:0] req_destination_address = '0;
   logic [15:0] req_source_port         = '0;
   logic [15:0] req_destination_port    = '0;
   logic [7:0]  req_protocol_number     = '0;
   logic [1:0]  req_read_row            = '0;
   logic [9:0]  req_read_column         = '0;
   logic        rsp_stall               = 1'b0;
   logic        csr_write_enable        = 1'b0;
   logic [1:0]  csr_index               = CSR_SEED_ROW0;
   logic [31:0] csr_write_data          = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [63:0] rsp_count_value;

   hash_type         row_seed [SEED_COUNT];
   count_type        sketch_cells [SKETCH_ROWS][SKETCH_COLS];
   count_type        pending_counts [$];
   flow_word_type    flow_pool [POOL_SIZE];
   directed_row_type directed_rows [$];

   int unsigned error_count   = 0;
   int unsigned count_words   = 0;
   int unsigned read_words    = 0;
   int unsigned seed_settings = 1;
   int unsigned sink_wait     = 0;
   int unsigned sink_left     = 0;
   int unsigned idle_cycles   = 0;
   bit          sink_calm     = 1'b0;
   bit          src_calm      = 1'b0;

   count_min_sketch_flow_counter u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_opcode              (req_opcode),
      .req_source_address      (req_source_address),
      .req_destination_address (req_destination_address),
      .req_source_port         (req_source_port),
      .req_destination_port    (req_destination_port),
      .req_protocol_number     (req_protocol_number),
      .req_read_row            (req_read_row),
      .req_read_column         (req_read_column),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_count_value         (rsp_count_value),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic hash_type tuple_hash(input hash_type seed, input flow_word_type w);
      hash_type h;
      h = seed ^ w.source_address;
      h = {h[18:0], h[31:19]} * MIX_MULT;
      h = h ^ w.destination_address;
      h = {h[18:0], h[31:19]} * MIX_MULT;
      h = h ^ {w.destination_port, w.source_port};
      h = {h[18:0], h[31:19]} * MIX_MULT;
      h = h ^ {24'd0, w.protocol_number};
      h = h ^ (h >> 15);
      h = h * FIN_MULT;
      h = h ^ (h >> 13);
      return h;
   endfunction

   function automatic logic [COL_BITS-1:0] cell_column(input hash_type seed,
                                                       input flow_word_type w);
      hash_type h;
      h = tuple_hash(seed, w) & hash_type'(SKETCH_COLS - 1);
      return h[COL_BITS-1:0];
   endfunction

   function automatic count_type apply_word(input flow_word_type w);
      count_type           lowest;
      logic [COL_BITS-1:0] col;
      int unsigned         r;
      if (w.opcode == OP_READ) begin
         if (w.read_row < SKETCH_ROWS && w.read_column < SKETCH_COLS)
            return sketch_cells[w.read_row][w.read_column];
         return '0;
      end
      lowest = '1;
      for (r = 0; r < SKETCH_ROWS; r++) begin
         col = cell_column(row_seed[r], w);
         sketch_cells[r][col] = sketch_cells[r][col] + 1;
         if (sketch_cells[r][col] < lowest)
            lowest = sketch_cells[r][col];
      end
      return lowest;
   endfunction

   function automatic flow_word_type random_word();
      flow_word_type w;
      int unsigned   pick;
      int unsigned   slot;
      w.opcode              = OP_COUNT;
      w.source_address      = $urandom();
      w.destination_address = $urandom();
      w.source_port         = 16'($urandom());
      w.destination_port    = 16'($urandom());
      w.protocol_number     = 8'($urandom());
      w.read_row            = 2'($urandom_range(0, 3));
      w.read_column         = 10'($urandom_range(0, SKETCH_COLS - 1));
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 55) begin
         w.source_address      = flow_pool[slot].source_address;
         w.destination_address = flow_pool[slot].destination_address;
         w.source_port         = flow_pool[slot].source_port;
         w.destination_port    = flow_pool[slot].destination_port;
         w.protocol_number     = flow_pool[slot].protocol_number;
      end else if (pick >= 70 && pick < 90) begin
         w.opcode      = OP_READ;
         w.read_column = cell_column(row_seed[w.read_row], flow_pool[slot]);
      end else if (pick >= 90) begin
         w.opcode = OP_READ;
      end
      return w;
   endfunction

   function void add_row(input logic op, input logic [31:0] sa, da,
                         input logic [15:0] sp, dp, input logic [7:0] proto,
                         input logic [1:0] row, input logic [9:0] col,
                         input bit aim, typed, input count_type value);
      directed_row_type d;
      d.word  = '{op, sa, da, sp, dp, proto, row, col};
      d.aim   = aim;
      d.typed = typed;
      d.value = value;
      directed_rows.push_back(d);
   endfunction

   task automatic send_word(input flow_word_type w, input bit typed, input count_type value);
      int unsigned gap;
      count_type   predicted;
      gap = src_calm ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode              <= w.opcode;
      req_source_address      <= w.source_address;
      req_destination_address <= w.destination_address;
      req_source_port         <= w.source_port;
      req_destination_port    <= w.destination_port;
      req_protocol_number     <= w.protocol_number;
      req_read_row            <= w.read_row;
      req_read_column         <= w.read_column;
      req_valid               <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = apply_word(w);
      pending_counts.push_back(typed ? value : predicted);
      if (w.opcode == OP_READ)
         read_words++;
      else
         count_words++;
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seeds(input hash_type s0, s1, s2, s3);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SEED_ROW0;
      csr_write_data   <= s0;
      @(negedge clock);
      csr_index        <= CSR_SEED_ROW1;
      csr_write_data   <= s1;
      @(negedge clock);
      csr_index        <= CSR_SEED_ROW2;
      csr_write_data   <= s2;
      @(negedge clock);
      csr_index        <= CSR_SEED_ROW3;
      csr_write_data   <= s3;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      row_seed[0] = s0;
      row_seed[1] = s1;
      row_seed[2] = s2;
      row_seed[3] = s3;
      seed_settings++;
   endtask

   task automatic run_random_phase(input int unsigned words);
      int unsigned k;
      for (k = 0; k < words; k++) begin
         if (k % 40 == 0)
            src_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 149) == 0)
            drain_and_settle();
         send_word(random_word(), 1'b0, '0);
      end
      drain_and_settle();
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            $error("unexpected word: count_value %0h", rsp_count_value);
            error_count++;
         end else begin
            if (rsp_count_value !== pending_counts[0]) begin
               $error("count_value mismatch: expected %0h actual %0h",
                      pending_counts[0], rsp_count_value);
               error_count++;
            end
            void'(pending_counts.pop_front());
         end
         if (sink_left == 0) begin
            sink_calm = ($urandom_range(0, 3) == 0);
            sink_left = 48;
         end
         sink_left--;
         sink_wait = sink_calm ? 0 : $urandom_range(0, 14);
      end else if (sink_wait != 0) begin
         sink_wait--;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (sink_wait != 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      flow_word_type w;
      flow_word_type aim_key;
      int unsigned   i;
      row_seed[0] = SEED_ROW0_RESET;
      row_seed[1] = SEED_ROW1_RESET;
      row_seed[2] = SEED_ROW2_RESET;
      row_seed[3] = SEED_ROW3_RESET;
      foreach (sketch_cells[r, c])
         sketch_cells[r][c] = '0;
      for (i = 0; i < POOL_SIZE; i++) begin
         flow_pool[i]                     = '0;
         flow_pool[i].source_address      = $urandom();
         flow_pool[i].destination_address = $urandom();
         flow_pool[i].source_port         = 16'($urandom());
         flow_pool[i].destination_port    = 16'($urandom());
         flow_pool[i].protocol_number     = 8'($urandom());
      end
      flow_pool[0] = '0;
      flow_pool[1] = '1;
      aim_key = '0;

      // reads after reset, key fields ignored on a read
      add_row(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd0, 10'd0, 0, 1, 64'd0);
      add_row(OP_READ, '1, '1, '1, '1, '1, 2'd3, 10'd1023, 0, 1, 64'd0);
      add_row(OP_READ, 32'h5555aaaa, 32'ha5a5a5a5, 16'h1234, 16'h8001, 8'h11,
              2'd2, 10'd512, 0, 1, 64'd0);
      // zero key twice, read fields ignored on a count
      add_row(OP_COUNT, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd0, 10'd0, 0, 1, 64'd1);
      add_row(OP_COUNT, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd3, 10'd1023, 0, 1, 64'd2);
      // field extremes
      add_row(OP_COUNT, '1, '1, '1, '1, '1, 2'd1, 10'd7, 0, 0, '0);
      add_row(OP_COUNT, '1, '1, '1, '1, '1, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, '1, 32'h0, 16'h0, 16'h0, 8'h0, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0, '1, 16'h0, 16'h0, 8'h0, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0, 32'h0, '1, 16'h0, 8'h0, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0, 32'h0, 16'h0, '1, 8'h0, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0, 32'h0, 16'h0, 16'h0, '1, 2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0a000001, 32'h0a000002, 16'd49152, 16'd443, 8'd6,
              2'd0, 10'd0, 0, 0, '0);
      add_row(OP_COUNT, 32'h0a000001, 32'h0a000002, 16'd49152, 16'd443, 8'd17,
              2'd0, 10'd0, 0, 0, '0);
      // read back the cells hit by the zero key, then one other cell
      add_row(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd0, 10'd0, 1, 0, '0);
      add_row(OP_READ, '1, 32'h0, 16'h0, 16'h0, 8'h0, 2'd1, 10'd0, 1, 0, '0);
      add_row(OP_READ, 32'h0, '1, 16'h0, 16'h0, 8'h0, 2'd2, 10'd0, 1, 0, '0);
      add_row(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd3, 10'd0, 1, 0, '0);
      add_row(OP_READ, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 2'd1, 10'd1, 0, 0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         w = directed_rows[k].word;
         if (directed_rows[k].aim)
            w.read_column = cell_column(row_seed[w.read_row], aim_key);
         send_word(w, directed_rows[k].typed, directed_rows[k].value);
      end
      drain_and_settle();

      run_random_phase(PHASE_WORDS);
      write_seeds('0, '0, '0, '0);
      run_random_phase(PHASE_WORDS);
      write_seeds('1, '1, '1, '1);
      run_random_phase(PHASE_WORDS);
      write_seeds($urandom(), $urandom(), $urandom(), $urandom());
      run_random_phase(PHASE_WORDS);
      write_seeds('0, '1, $urandom(), 32'h80000001);
      run_random_phase(PHASE_WORDS);

      $display("covered %0d count words and %0d read words over %0d seed settings",
               count_words, read_words, seed_settings);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
